// ===== rtl/lcal_pkg.sv =====
// Shared types and constants for the lowest-common-ancestor lifting block.
// No dependencies; imported by lowest_common_ancestor_lifting and its testbench.
package lcal_pkg;

    // Node numbering and table entry formats.
    localparam int MAX_NODES = 4096;
    localparam int NODE_W    = 12;
    localparam int ENTRY_W   = 13;
    localparam int DEPTH_W   = 12;
    localparam int COUNT_W   = 13;

    typedef logic [NODE_W-1:0]  node_t;
    typedef logic [ENTRY_W-1:0] entry_t;
    typedef logic [DEPTH_W-1:0] depth_t;

    // An entry of this value means "no ancestor".
    localparam entry_t NONE_MARK = entry_t'(MAX_NODES);

    // Command codes on the kind field.
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_BUILD = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    // Reset value of the node count register.
    localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = COUNT_W'(MAX_NODES);

endpackage

// ===== rtl/lcal_ram.sv =====
// Synchronous RAM with one write port and two registered read ports.
// Depends on nothing but its parameters; used for the jump and depth tables.
module lcal_ram
#(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and two registered read ports.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== rtl/lowest_common_ancestor_lifting.sv =====
// Lowest common ancestor by binary lifting: control sequencer and APB register.
// Depends on lcal_pkg and two lcal_ram instances (jump table, depth table).
//
//   Channel   Signals                               Transfer when
//   --------  ------------------------------------  -------------------------------
//   command   start, busy, kind, node, other, depth start high while busy is low
//   result    done, ancestor                        done high (one cycle, no stall)
//   config    psel, penable, pwrite, paddr, pwdata,  psel, penable, pwrite, pready
//             prdata, pready
//
// A load leaves busy low. A build fills levels 1 to LEVELS - 1 for each node
// below the node count: a jump-table read, a read of the ancestor's own entry
// when one exists, and a write per entry. A query reads the depth table, then
// one jump-table read per lift and joint step. Reset clears the sequencer and
// sets the node count to MAX_NODES; the tables hold nothing defined until
// loaded. The result is a single-cycle strobe that the receiver cannot stall.
module lowest_common_ancestor_lifting
    import lcal_pkg::*;
#(
    parameter int LEVELS = 12
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  logic [1:0]   kind,
    input  logic [11:0]  node,
    input  logic [12:0]  other,
    input  logic [11:0]  depth,
    output logic         done,
    output logic [11:0]  ancestor,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int LW         = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int JDEPTH     = LEVELS * MAX_NODES;
    localparam int JAW        = $clog2(JDEPTH);
    localparam int LAST_BUILD = (LEVELS > 1) ? LEVELS - 2 : 0;
    localparam depth_t DIFF_MASK = (LEVELS >= DEPTH_W) ? {DEPTH_W{1'b1}}
                                                        : DEPTH_W'((1 << LEVELS) - 1);

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_QDEP   = 4'd1;
    localparam logic [3:0] S_LIFT   = 4'd2;
    localparam logic [3:0] S_LIFTW  = 4'd3;
    localparam logic [3:0] S_JSTART = 4'd4;
    localparam logic [3:0] S_JRD    = 4'd5;
    localparam logic [3:0] S_JCHK   = 4'd6;
    localparam logic [3:0] S_FRD    = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;
    localparam logic [3:0] S_BRD1   = 4'd9;
    localparam logic [3:0] S_BRD2   = 4'd10;
    localparam logic [3:0] S_BWR    = 4'd11;

    logic [3:0]          state_reg, state_next;
    node_t               u_reg, u_next;
    node_t               v_reg, v_next;
    depth_t              diff_reg, diff_next;
    logic [LW-1:0]       lvl_reg, lvl_next;
    node_t               idx_reg, idx_next;
    node_t               last_reg, last_next;
    logic [COUNT_W-1:0]  node_count_reg;
    logic                done_reg, done_next;
    node_t               ancestor_reg, ancestor_next;

    logic                accept;
    logic                cfg_write;

    // Table port controls.
    logic                jwe;
    logic [LW-1:0]       jw_lvl;
    node_t               jw_node;
    entry_t              jw_data;
    logic [LW-1:0]       jra_lvl;
    node_t               jra_node;
    node_t               jrb_node;
    entry_t              j_rd_a;
    entry_t              j_rd_b;
    logic                dwe;
    node_t               dra;
    node_t               drb;
    depth_t              d_rd_a;
    depth_t              d_rd_b;
    entry_t              load_parent;

    // Jump table address: level in the upper bits, node in the lower bits.
    function automatic logic [JAW-1:0] jaddr(input logic [LW-1:0] lvl, input node_t n);
        jaddr = JAW'({lvl, n});
    endfunction

    assign accept    = start && !busy;
    assign cfg_write = psel && penable && pwrite && pready;
    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign ancestor  = ancestor_reg;
    assign pready    = 1'b1;

    // Register read: node_count is read whenever paddr[2] is low; the rest read zero.
    assign prdata = paddr[2] ? 32'd0 : {{(32 - COUNT_W){1'b0}}, node_count_reg};

    // A parent at or beyond the node range is stored as no ancestor.
    assign load_parent = other[12] ? NONE_MARK : {1'b0, other[11:0]};

    // Jump table: ancestors at distance 2^level.
    lcal_ram
    #(
        .WIDTH (ENTRY_W),
        .DEPTH (JDEPTH)
    )
    u_jump_ram
    (
        .clk     (clk),
        .we      (jwe),
        .waddr   (jaddr(jw_lvl, jw_node)),
        .wdata   (jw_data),
        .raddr_a (jaddr(jra_lvl, jra_node)),
        .raddr_b (jaddr(jra_lvl, jrb_node)),
        .rdata_a (j_rd_a),
        .rdata_b (j_rd_b)
    );

    // Depth table, read for both query nodes at once.
    lcal_ram
    #(
        .WIDTH (DEPTH_W),
        .DEPTH (MAX_NODES)
    )
    u_depth_ram
    (
        .clk     (clk),
        .we      (dwe),
        .waddr   (node),
        .wdata   (depth),
        .raddr_a (dra),
        .raddr_b (drb),
        .rdata_a (d_rd_a),
        .rdata_b (d_rd_b)
    );

    // Sequencer: load, table build and query walk.
    always_comb
    begin
        state_next    = state_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        diff_next     = diff_reg;
        lvl_next      = lvl_reg;
        idx_next      = idx_reg;
        last_next     = last_reg;
        done_next     = 1'b0;
        ancestor_next = ancestor_reg;
        jwe           = 1'b0;
        jw_lvl        = LW'(lvl_reg + 1'b1);
        jw_node       = idx_reg;
        jw_data       = NONE_MARK;
        jra_lvl       = lvl_reg;
        jra_node      = u_reg;
        jrb_node      = v_reg;
        dwe           = 1'b0;
        dra           = node;
        drb           = other[11:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind)
                        KIND_LOAD:
                        begin
                            jwe     = 1'b1;
                            jw_lvl  = '0;
                            jw_node = node;
                            jw_data = load_parent;
                            dwe     = 1'b1;
                        end
                        KIND_BUILD:
                        begin
                            if (node_count_reg != '0 && LEVELS > 1)
                            begin
                                lvl_next   = '0;
                                idx_next   = '0;
                                last_next  = (node_count_reg > COUNT_W'(MAX_NODES))
                                           ? NODE_W'(MAX_NODES - 1)
                                           : NODE_W'(node_count_reg - 1'b1);
                                state_next = S_BRD1;
                            end
                        end
                        KIND_QUERY:
                        begin
                            u_next     = node;
                            v_next     = other[11:0];
                            state_next = S_QDEP;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_QDEP:
            begin
                // Make the first node the deeper one.
                if (d_rd_a < d_rd_b)
                begin
                    u_next    = v_reg;
                    v_next    = u_reg;
                    diff_next = (d_rd_b - d_rd_a) & DIFF_MASK;
                end
                else
                begin
                    diff_next = (d_rd_a - d_rd_b) & DIFF_MASK;
                end
                lvl_next   = '0;
                state_next = S_LIFT;
            end
            S_LIFT:
            begin
                if (diff_reg == '0)
                begin
                    state_next = S_JSTART;
                end
                else if (diff_reg[0])
                begin
                    state_next = S_LIFTW;
                end
                else
                begin
                    diff_next = diff_reg >> 1;
                    lvl_next  = LW'(lvl_reg + 1'b1);
                end
            end
            S_LIFTW:
            begin
                if (j_rd_a != NONE_MARK)
                begin
                    u_next = j_rd_a[NODE_W-1:0];
                end
                diff_next  = diff_reg >> 1;
                lvl_next   = LW'(lvl_reg + 1'b1);
                state_next = S_LIFT;
            end
            S_JSTART:
            begin
                if (u_reg == v_reg)
                begin
                    done_next     = 1'b1;
                    ancestor_next = u_reg;
                    state_next    = S_IDLE;
                end
                else
                begin
                    lvl_next   = LW'(LEVELS - 1);
                    state_next = S_JRD;
                end
            end
            S_JRD:
            begin
                state_next = S_JCHK;
            end
            S_JCHK:
            begin
                // Jump together only when both targets exist and differ.
                if (j_rd_a != NONE_MARK && j_rd_b != NONE_MARK && j_rd_a != j_rd_b)
                begin
                    u_next = j_rd_a[NODE_W-1:0];
                    v_next = j_rd_b[NODE_W-1:0];
                end
                if (lvl_reg == '0)
                begin
                    state_next = S_FRD;
                end
                else
                begin
                    lvl_next   = LW'(lvl_reg - 1'b1);
                    state_next = S_JRD;
                end
            end
            S_FRD:
            begin
                jra_lvl    = '0;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                done_next     = 1'b1;
                ancestor_next = (j_rd_a == NONE_MARK) ? u_reg : j_rd_a[NODE_W-1:0];
                state_next    = S_IDLE;
            end
            S_BRD1:
            begin
                jra_node   = idx_reg;
                state_next = S_BRD2;
            end
            S_BRD2, S_BWR:
            begin
                if (state_reg == S_BRD2 && j_rd_a != NONE_MARK)
                begin
                    // Fetch the ancestor's own entry at this level.
                    jra_node   = j_rd_a[NODE_W-1:0];
                    state_next = S_BWR;
                end
                else
                begin
                    jwe     = 1'b1;
                    jw_data = (state_reg == S_BWR) ? j_rd_a : NONE_MARK;
                    if (idx_reg == last_reg)
                    begin
                        if (lvl_reg == LW'(LAST_BUILD))
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            lvl_next   = LW'(lvl_reg + 1'b1);
                            idx_next   = '0;
                            state_next = S_BRD1;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_BRD1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            done_reg       <= 1'b0;
            node_count_reg <= NODE_COUNT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_write && !paddr[2])
            begin
                node_count_reg <= pwdata[COUNT_W-1:0];
            end
        end
    end

    // Working registers of the walk.
    always_ff @(posedge clk)
    begin
        u_reg        <= u_next;
        v_reg        <= v_next;
        diff_reg     <= diff_next;
        lvl_reg      <= lvl_next;
        idx_reg      <= idx_next;
        last_reg     <= last_next;
        ancestor_reg <= ancestor_next;
    end

`ifndef SYNTHESIS
    // A result only follows the end of a query walk.
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == S_FIN || $past(state_reg) == S_JSTART))
        else $error("result strobe without a finished query");

    // Each query gives a single one-cycle strobe.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe longer than one cycle");

    // The build never writes level zero, which holds the loaded parents.
    a_build_lvl: assert property (@(posedge clk) disable iff (!rst_n)
        (jwe && state_reg != S_IDLE) |-> (jw_lvl != '0))
        else $error("build wrote the parent level");

    // An accepted query keeps the block busy in the following cycle.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == KIND_QUERY) |=> busy)
        else $error("query transfer did not start a walk");
`endif

endmodule

// ===== bench/tb_lowest_common_ancestor_lifting.sv =====
`timescale 1ns / 1ps
// Testbench for lowest_common_ancestor_lifting: a directed small tree, then random trees.
// Depends on lcal_pkg and the block itself; ancestors are predicted by a lifting model here.
module tb_lowest_common_ancestor_lifting
    import lcal_pkg::*;
();

    localparam int LVL = 12;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [2:0] ADDR_NODE_COUNT = 3'd0;
    localparam int SETTLE_CYCLES = 4 * LVL + 16;
    // The largest build here, 300 nodes, runs with no transfer at all.
    localparam int STALL_LIMIT = 50000;
    localparam int RANDOM_ITEMS = 1800;

    typedef struct packed {
        logic [1:0] kind;
        node_t      node;
        entry_t     other;
        depth_t     depth;
        logic       typed;
        node_t      want;
    } dir_row_t;

    // Directed tree: 0 is root of 1 and 2, chain 1-3-4-5, 6 under 2, 7 a second root.
    localparam int DIR_ROWS = 25;
    localparam dir_row_t DIR_TBL [DIR_ROWS] = '{
        {KIND_LOAD,   12'd0,   NONE_MARK,   12'd0,   1'b0, 12'd0},
        {KIND_LOAD,   12'd1,   13'd0,       12'd1,   1'b0, 12'd0},
        {KIND_LOAD,   12'd2,   13'd0,       12'd1,   1'b0, 12'd0},
        {KIND_LOAD,   12'd3,   13'd1,       12'd2,   1'b0, 12'd0},
        {KIND_LOAD,   12'd4,   13'd3,       12'd3,   1'b0, 12'd0},
        {KIND_LOAD,   12'd5,   13'd4,       12'd4,   1'b0, 12'd0},
        {KIND_LOAD,   12'd6,   13'd2,       12'd2,   1'b0, 12'd0},
        {KIND_LOAD,   12'd7,   13'h1FFF,    12'd0,   1'b0, 12'd0},
        {KIND_UNUSED, 12'hFFF, 13'h1FFF,    12'hFFF, 1'b0, 12'd0},
        {KIND_BUILD,  12'd0,   13'd0,       12'd0,   1'b0, 12'd0},
        {KIND_QUERY,  12'd5,   13'd6,       12'd0,   1'b1, 12'd0},
        {KIND_QUERY,  12'd6,   13'd5,       12'd0,   1'b1, 12'd0},
        {KIND_QUERY,  12'd5,   13'd5,       12'd0,   1'b1, 12'd5},
        {KIND_QUERY,  12'd0,   13'd5,       12'd0,   1'b1, 12'd0},
        {KIND_QUERY,  12'd5,   13'd3,       12'd0,   1'b1, 12'd3},
        {KIND_QUERY,  12'd4,   13'd4102,    12'd0,   1'b1, 12'd0},
        {KIND_QUERY,  12'd7,   13'd7,       12'd0,   1'b1, 12'd7},
        {KIND_QUERY,  12'd4,   13'd1,       12'd0,   1'b1, 12'd1},
        {KIND_QUERY,  12'd5,   13'd7,       12'd0,   1'b0, 12'd0},
        {KIND_QUERY,  12'd6,   13'd3,       12'd0,   1'b0, 12'd0},
        {KIND_LOAD,   12'd6,   13'd2,       12'd9,   1'b0, 12'd0},
        {KIND_QUERY,  12'd6,   13'd5,       12'd0,   1'b0, 12'd0},
        {KIND_LOAD,   12'd7,   NONE_MARK,   12'hFFF, 1'b0, 12'd0},
        {KIND_QUERY,  12'd0,   13'd7,       12'd0,   1'b0, 12'd0},
        {KIND_QUERY,  12'd7,   13'd3,       12'd0,   1'b0, 12'd0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  kind = '0;
    node_t       node = '0;
    entry_t      other = '0;
    depth_t      depth = '0;
    logic        done;
    node_t       ancestor;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state: ancestor table, depths and the node count register.
    entry_t             model_jump [MAX_NODES][LVL];
    depth_t             model_depth [MAX_NODES];
    logic [COUNT_W-1:0] model_count;
    node_t              pending_ancestors [$];

    // Scratch for random tree generation.
    int     tree_order [MAX_NODES];
    int     tree_depth [MAX_NODES];

    int     errors = 0;
    int     items_sent = 0;
    int     idle_pct = 0;
    int     quiet_cycles = 0;
    node_t  want_anc;

    lowest_common_ancestor_lifting #(.LEVELS(LVL)) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .node(node), .other(other), .depth(depth), .done(done), .ancestor(ancestor),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Fill levels 1 and up for the nodes below the node count.
    function automatic void model_build();
        int lim;
        entry_t p;
        lim = (model_count > MAX_NODES) ? MAX_NODES : int'(model_count);
        for (int k = 0; k + 1 < LVL; k++)
        begin
            for (int i = 0; i < lim; i++)
            begin
                p = model_jump[i][k];
                model_jump[i][k+1] = (p == NONE_MARK) ? NONE_MARK
                                                      : model_jump[p[NODE_W-1:0]][k];
            end
        end
    endfunction

    // Lift the deeper node to the same depth, then jump both from the top level down.
    function automatic node_t predict_lca(input node_t a, input node_t b);
        node_t  u;
        node_t  v;
        depth_t diff;
        entry_t pu;
        entry_t pv;
        u = a;
        v = b;
        if (model_depth[u] < model_depth[v])
        begin
            u = b;
            v = a;
        end
        diff = model_depth[u] - model_depth[v];
        for (int j = 0; j < LVL; j++)
        begin
            pu = model_jump[u][j];
            if (diff[j] && pu != NONE_MARK)
                u = pu[NODE_W-1:0];
        end
        if (u != v)
        begin
            for (int j = LVL - 1; j >= 0; j--)
            begin
                pu = model_jump[u][j];
                pv = model_jump[v][j];
                if (pu != NONE_MARK && pv != NONE_MARK && pu != pv)
                begin
                    u = pu[NODE_W-1:0];
                    v = pv[NODE_W-1:0];
                end
            end
            pu = model_jump[u][0];
            if (pu != NONE_MARK)
                u = pu[NODE_W-1:0];
        end
        return u;
    endfunction

    // Update the predictor for one accepted command.
    function automatic void model_accept(input logic [1:0] k, input node_t n, input entry_t o,
                                         input depth_t d, input logic typed, input node_t want);
        case (k)
            KIND_LOAD:
            begin
                model_jump[n][0] = (o >= NONE_MARK) ? NONE_MARK : o;
                model_depth[n] = d;
            end
            KIND_BUILD:
                model_build();
            KIND_QUERY:
                pending_ancestors.insert(pending_ancestors.size(),
                                         typed ? want : predict_lca(n, o[NODE_W-1:0]));
            default:
                ;
        endcase
    endfunction

    // Drive one command, with random idle cycles ahead of it, and wait for its transfer.
    task automatic issue_cmd(input logic [1:0] k, input node_t n, input entry_t o,
                             input depth_t d, input logic typed, input node_t want);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        kind <= k;
        node <= n;
        other <= o;
        depth <= d;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        model_accept(k, n, o, d, typed, want);
        if (k != KIND_UNUSED)
            items_sent++;
    endtask

    // Occasionally slip in a command with the unused kind code.
    task automatic maybe_noise();
        if ($urandom_range(99) < 2)
            issue_cmd(KIND_UNUSED, node_t'($urandom), entry_t'($urandom),
                      depth_t'($urandom), 1'b0, '0);
    endtask

    task automatic apb_write(input logic [2:0] a, input logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_read(input logic [2:0] a, output logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= a;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        data = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Read the node count back and compare it with the predicted register.
    task automatic check_node_count();
        logic [31:0] rd;
        apb_read(ADDR_NODE_COUNT, rd);
        if (rd[COUNT_W-1:0] !== model_count)
        begin
            $display("%0t: node_count read expected %0d got %0d", $time, model_count,
                     rd[COUNT_W-1:0]);
            errors++;
        end
    endtask

    task automatic set_node_count(input int cnt);
        apb_write(ADDR_NODE_COUNT, 32'(cnt));
        model_count = COUNT_W'(cnt);
        check_node_count();
    endtask

    // Let every pending query come back and the sequencer fall idle.
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (pending_ancestors.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Load a random tree over nodes 0..n_nodes-1, build, then query it, with some relinks and rebuilds mixed in.
    task automatic run_tree(input int n_nodes, input int queries);
        int     j;
        int     u;
        int     v;
        int     r;
        entry_t par;
        depth_t dep;
        for (int i = 0; i < n_nodes; i++)
            tree_order[i] = i;
        for (int i = n_nodes - 1; i > 0; i--)
        begin
            j = $urandom_range(i, 0);
            u = tree_order[i];
            tree_order[i] = tree_order[j];
            tree_order[j] = u;
        end
        // Mostly chains, so that the upper table levels get used.
        for (int i = 0; i < n_nodes; i++)
        begin
            u = tree_order[i];
            if (i == 0 || $urandom_range(99) < 3)
            begin
                par = $urandom_range(1) ? NONE_MARK : entry_t'($urandom_range(8191, 4096));
                tree_depth[u] = 0;
            end
            else
            begin
                j = ($urandom_range(3) != 0) ? i - 1 : $urandom_range(i - 1, 0);
                par = entry_t'(tree_order[j]);
                tree_depth[u] = tree_depth[tree_order[j]] + 1;
            end
            dep = ($urandom_range(99) < 2) ? depth_t'($urandom) : depth_t'(tree_depth[u]);
            maybe_noise();
            issue_cmd(KIND_LOAD, node_t'(u), par, dep, 1'b0, '0);
        end
        issue_cmd(KIND_BUILD, node_t'($urandom), entry_t'($urandom), depth_t'($urandom),
                  1'b0, '0);
        for (int q = 0; q < queries; q++)
        begin
            maybe_noise();
            r = $urandom_range(99);
            u = $urandom_range(n_nodes - 1, 0);
            if (r < 4)
            begin
                // Relink a node inside the tree; entries stay defined.
                par = $urandom_range(3) ? entry_t'($urandom_range(n_nodes - 1, 0)) : NONE_MARK;
                issue_cmd(KIND_LOAD, node_t'(u), par, depth_t'($urandom), 1'b0, '0);
            end
            else if (r < 6)
                issue_cmd(KIND_BUILD, node_t'($urandom), entry_t'($urandom),
                          depth_t'($urandom), 1'b0, '0);
            else
            begin
                v = ($urandom_range(9) == 0) ? u : $urandom_range(n_nodes - 1, 0);
                if ($urandom_range(3) == 0)
                    v = v + MAX_NODES;
                issue_cmd(KIND_QUERY, node_t'(u), entry_t'(v), depth_t'($urandom), 1'b0, '0);
            end
        end
    endtask

    // Compare each result transfer with the oldest expected ancestor.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_ancestors.size() == 0)
            begin
                $display("%0t: ancestor %0d with no query waiting", $time, ancestor);
                errors++;
            end
            else
            begin
                want_anc = pending_ancestors.pop_front();
                if (ancestor !== want_anc)
                begin
                    $display("%0t: ancestor expected %0d got %0d", $time, want_anc, ancestor);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (psel && penable && pwrite && pready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int phase;
        int n_nodes;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Register reset value, then the directed tree.
        model_count = NODE_COUNT_RESET;
        check_node_count();
        set_node_count(8);
        idle_pct = 0;
        for (int i = 0; i < DIR_ROWS; i++)
            issue_cmd(DIR_TBL[i].kind, DIR_TBL[i].node, DIR_TBL[i].other, DIR_TBL[i].depth,
                      DIR_TBL[i].typed, DIR_TBL[i].want);
        settle();

        // Random trees, mostly small, with the smallest node counts first.
        items_sent = 0;
        phase = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            idle_pct = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 47 : 15;
            if (phase == 0)
                n_nodes = 1;
            else if (phase == 1)
                n_nodes = 2;
            else if ($urandom_range(5) == 0)
                n_nodes = $urandom_range(300, 100);
            else
                n_nodes = $urandom_range(48, 3);
            set_node_count(n_nodes);
            run_tree(n_nodes, $urandom_range(40, 10));
            settle();
            phase++;
        end

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
